>>> design/prt_pkg.sv
package prt_pkg;

   localparam int USER_SLOTS_DEF  = 4096;
   localparam int PAGE_LEVELS_DEF = 1024;

   localparam int UID_W   = 12;
   localparam int PAGE_W  = 10;
   localparam int CNT_W   = 12;
   localparam int RATIO_W = 17;

   localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;
   localparam logic [CNT_W-1:0]   CNT_MAX   = 12'hfff;

   localparam logic REQ_RECORD = 1'b0;
   localparam logic REQ_RANK   = 1'b1;

   // classified request, front to back
   typedef struct packed {
      logic              is_rank;
      logic              in_range;
      logic [UID_W-1:0]  user_id;
      logic [PAGE_W-1:0] page;
   } req_item_type;

   typedef struct packed {
      logic               user_known;
      logic [CNT_W-1:0]   fewer_count;
      logic [CNT_W-1:0]   others_count;
      logic [RATIO_W-1:0] rank_ratio;
   } rsp_item_type;

endpackage

>>> design/progress_rank_tracker.sv
// Record beat in the back end: user lookup and new bin for a first record; a repeat adds an
// old bin read-modify-write. Rank beat: an unknown user or a zero page count goes straight to
// the output, else a sum over the bins below P = stored page count (one histogram read per
// cycle), then a serial divide of W + 16 bits, W = $clog2(USER_SLOTS + 1), if others exist.
// A 4-deep queue takes request beats while the back end works; one output register. Reset is
// synchronous; a clearing pass over max(USER_SLOTS, PAGE_LEVELS) addresses follows it.
module progress_rank_tracker
   import prt_pkg::*;
#(
   parameter int USER_SLOTS  = USER_SLOTS_DEF,
   parameter int PAGE_LEVELS = PAGE_LEVELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // user_id[11:0], pages_read[21:12], zero pad
   input  logic        req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // user_known[0], fewer_count[12:1],
                                   // others_count[24:13], rank_ratio[41:25], zero pad
);

   req_item_type item;
   logic         item_valid, item_pop;
   rsp_item_type rsp;

   prt_front #(.USER_SLOTS(USER_SLOTS), .PAGE_LEVELS(PAGE_LEVELS)) u_front (
      .clock, .reset,
      .req_valid(req_tvalid), .req_ready(req_tready),
      .req_kind(req_tuser), .req_user_id(req_tdata[11:0]),
      .req_pages(req_tdata[21:12]),
      .item_valid, .item, .item_pop
   );

   prt_back #(.USER_SLOTS(USER_SLOTS), .PAGE_LEVELS(PAGE_LEVELS)) u_back (
      .clock, .reset,
      .item_valid, .item, .item_pop,
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp
   );

   assign rsp_tdata = {6'b0, rsp.rank_ratio, rsp.others_count,
                       rsp.fewer_count, rsp.user_known};

endmodule

>>> design/prt_ram.sv
module prt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/prt_front.sv
module prt_front
   import prt_pkg::*;
#(
   parameter int USER_SLOTS  = USER_SLOTS_DEF,
   parameter int PAGE_LEVELS = PAGE_LEVELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [UID_W-1:0]  req_user_id,
   input  logic [PAGE_W-1:0] req_pages,
   output logic              item_valid,
   output req_item_type      item,
   input  logic              item_pop
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   req_item_type           fifo_ff [DEPTH];
   logic [PTR_W-1:0]       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [PTR_W:0]         count_ff, count_in;
   req_item_type           classified;
   logic                   push;

   always_comb begin
      classified.is_rank  = (req_kind == REQ_RANK);
      classified.in_range = (32'(req_user_id) < 32'(USER_SLOTS));
      classified.user_id  = req_user_id;
      classified.page     = (32'(req_pages) >= 32'(PAGE_LEVELS)) ?
                            PAGE_W'(PAGE_LEVELS - 1) : req_pages;
   end

   assign req_ready  = (32'(count_ff) < DEPTH);
   assign push       = req_valid && req_ready;
   assign item_valid = (count_ff != '0);
   assign item       = fifo_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = item_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         fifo_ff[wptr_ff] <= classified;
      end
   end

endmodule

>>> design/prt_div.sv
module prt_div #(
   parameter int CW = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CW-1:0]    dividend,
   input  logic [CW-1:0]    divisor,
   output logic             done,
   output logic [CW+15:0]   quotient
);

   localparam int N   = CW + 16;
   localparam int NCW = $clog2(N + 1);

   logic [CW:0]    rem_ff, rem_in;
   logic [N-1:0]   quo_ff, quo_in;
   logic [CW-1:0]  div_ff, div_in;
   logic [NCW-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [CW:0]    rem_sh;

   // one quotient bit per cycle, restoring
   always_comb begin
      rem_sh  = {rem_ff[CW-1:0], quo_ff[N-1]};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = {dividend, 16'h0000};
         div_in  = divisor;
         cnt_in  = NCW'(N);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_in = rem_sh - {1'b0, div_ff};
            quo_in = {quo_ff[N-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[N-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == NCW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> design/prt_back.sv
module prt_back
   import prt_pkg::*;
#(
   parameter int USER_SLOTS  = USER_SLOTS_DEF,
   parameter int PAGE_LEVELS = PAGE_LEVELS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  req_item_type item,
   output logic         item_pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp
);

   localparam int UAW  = $clog2(USER_SLOTS);
   localparam int PW   = $clog2(PAGE_LEVELS);
   localparam int CW   = $clog2(USER_SLOTS + 1);
   localparam int MAXD = (USER_SLOTS > PAGE_LEVELS) ? USER_SLOTS : PAGE_LEVELS;
   localparam int CLW  = $clog2(MAXD);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ULOOK, S_HDEC, S_HRDN, S_HINC,
      S_SUM, S_SUMEND, S_DIVGO, S_DIV, S_OUT
   } state_type;

   state_type     state_ff, state_in;
   logic [CLW-1:0] clr_ff, clr_in;
   req_item_type  item_ff, item_in;
   logic [PW-1:0] page_ff, page_in;
   logic [PW-1:0] idx_ff, idx_in;
   logic [CW-1:0] acc_ff, acc_in;
   logic [CW-1:0] act_ff, act_in;
   logic [CW-1:0] others_ff, others_in;
   logic          known_ff, known_in;
   logic [RATIO_W-1:0] ratio_ff, ratio_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_ff, rsp_in;

   // user store: {active, pages}
   logic          u_we;
   logic [UAW-1:0] u_waddr, u_raddr;
   logic [PW:0]   u_wdata, u_rdata;
   logic          h_we;
   logic [PW-1:0] h_waddr, h_raddr;
   logic [CW-1:0] h_wdata, h_rdata;

   logic          div_start, div_done;
   logic [CW+15:0] div_quo;
   logic          u_active;
   logic [PW-1:0] item_page;

   prt_ram #(.WIDTH(PW + 1), .DEPTH(USER_SLOTS)) u_user_ram (
      .clock, .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
      .raddr(u_raddr), .rdata(u_rdata)
   );

   prt_ram #(.WIDTH(CW), .DEPTH(PAGE_LEVELS)) u_hist_ram (
      .clock, .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
      .raddr(h_raddr), .rdata(h_rdata)
   );

   prt_div #(.CW(CW)) u_div (
      .clock, .reset, .start(div_start), .dividend(acc_ff), .divisor(others_ff),
      .done(div_done), .quotient(div_quo)
   );

   assign u_active  = item_ff.in_range && u_rdata[PW];
   assign item_page = PW'(item_ff.page);

   function automatic logic [CNT_W-1:0] sat12(input logic [CW-1:0] v);
      return (32'(v) > 32'(CNT_MAX)) ? CNT_MAX : CNT_W'(v);
   endfunction

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      item_in      = item_ff;
      page_in      = page_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      act_in       = act_ff;
      others_in    = others_ff;
      known_in     = known_ff;
      ratio_in     = ratio_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      item_pop     = 1'b0;
      u_we         = 1'b0;
      u_waddr      = UAW'(item_ff.user_id);
      u_wdata      = {1'b1, item_page};
      u_raddr      = UAW'(item.user_id);
      h_we         = 1'b0;
      h_waddr      = page_ff;
      h_wdata      = h_rdata + 1'b1;
      h_raddr      = idx_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            u_we    = (32'(clr_ff) < 32'(USER_SLOTS));
            u_waddr = UAW'(clr_ff);
            u_wdata = '0;
            h_we    = (32'(clr_ff) < 32'(PAGE_LEVELS));
            h_waddr = PW'(clr_ff);
            h_wdata = '0;
            clr_in  = clr_ff + 1'b1;
            if (32'(clr_ff) == MAXD - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               item_in  = item;
               state_in = S_ULOOK;
            end
         end
         S_ULOOK: begin
            page_in = u_rdata[PW-1:0];
            if (!item_ff.is_rank) begin
               if (!item_ff.in_range) begin
                  state_in = S_IDLE;
               end else begin
                  u_we = 1'b1;
                  if (u_active) begin
                     h_raddr  = u_rdata[PW-1:0];
                     state_in = S_HDEC;
                  end else begin
                     act_in   = act_ff + 1'b1;
                     page_in  = item_page;
                     h_raddr  = item_page;
                     state_in = S_HINC;
                  end
               end
            end else begin
               known_in  = u_active;
               acc_in    = '0;
               idx_in    = '0;
               ratio_in  = '0;
               if (!u_active) begin
                  others_in = act_ff;
                  state_in  = S_OUT;
               end else begin
                  others_in = act_ff - 1'b1;
                  state_in  = (u_rdata[PW-1:0] == '0) ? S_OUT : S_SUM;
               end
            end
         end
         S_HDEC: begin
            // drop the old bin
            h_we    = (h_rdata != '0);
            h_wdata = h_rdata - 1'b1;
            state_in = S_HRDN;
         end
         S_HRDN: begin
            page_in  = item_page;
            h_raddr  = item_page;
            state_in = S_HINC;
         end
         S_HINC: begin
            h_we     = 1'b1;
            state_in = S_IDLE;
         end
         S_SUM: begin
            h_raddr = idx_ff;
            if (idx_ff != '0) begin
               acc_in = acc_ff + h_rdata;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == page_ff - 1'b1) begin
               state_in = S_SUMEND;
            end
         end
         S_SUMEND: begin
            acc_in   = acc_ff + h_rdata;
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            if (others_ff == '0) begin
               ratio_in = RATIO_ONE;
               state_in = S_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               ratio_in = (div_quo > (CW+16)'(RATIO_ONE)) ? RATIO_ONE
                                                           : RATIO_W'(div_quo);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.user_known   = known_ff;
               rsp_in.fewer_count  = sat12(acc_ff);
               rsp_in.others_count = sat12(others_ff);
               rsp_in.rank_ratio   = ratio_ff;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         act_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff   <= item_in;
      page_ff   <= page_in;
      idx_ff    <= idx_in;
      acc_ff    <= acc_in;
      others_ff <= others_in;
      known_ff  <= known_in;
      ratio_ff  <= ratio_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
